### hw/rtl/ctnc_pkg.sv
package ctnc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW_COUNTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_WHOLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FRAC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_RATE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_OFFSET   = 3'd5;

    // source_mode codes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_EVENT = 2'd1;
    localparam logic [1:0] MODE_CYCLE = 2'd2;

    localparam logic [31:0] PPM_DIV        = 32'd1000000;
    localparam logic [31:0] RATE_KHZ_RESET = 32'd1000;
    localparam logic [63:0] HALF_WRAP      = 64'h0000_0000_7fff_ffff;
    localparam logic [63:0] WRAP_STEP      = 64'h0000_0001_0000_0000;

    typedef struct packed {
        logic [1:0]  source_mode;
        logic        narrow_counter;
        logic [6:0]  period_whole_ns;
        logic [19:0] period_frac_ppm;
        logic [31:0] cycle_rate_khz;
        logic [63:0] cycle_offset_ns;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EXTEND,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        MUL_WHOLE,
        MUL_FRAC,
        MUL_PPM
    } t_mul_sel;

    typedef struct packed {
        t_op      op;
        t_mul_sel mul_sel;
    } t_cmd;

endpackage

### hw/rtl/ctnc_cfg.sv
module ctnc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ctnc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ctnc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ctnc_pkg::t_cfg                     o_cfg
);

    ctnc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_mode     <= ctnc_pkg::MODE_NONE;
            r_cfg.narrow_counter  <= 1'b0;
            r_cfg.period_whole_ns <= '0;
            r_cfg.period_frac_ppm <= '0;
            r_cfg.cycle_rate_khz  <= ctnc_pkg::RATE_KHZ_RESET;
            r_cfg.cycle_offset_ns <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ctnc_pkg::CFG_SOURCE_MODE:    r_cfg.source_mode     <= i_cfg_data[1:0];
                ctnc_pkg::CFG_NARROW_COUNTER: r_cfg.narrow_counter  <= i_cfg_data[0];
                ctnc_pkg::CFG_PERIOD_WHOLE:   r_cfg.period_whole_ns <= i_cfg_data[6:0];
                ctnc_pkg::CFG_PERIOD_FRAC:    r_cfg.period_frac_ppm <= i_cfg_data[19:0];
                ctnc_pkg::CFG_CYCLE_RATE:     r_cfg.cycle_rate_khz  <= i_cfg_data[31:0];
                ctnc_pkg::CFG_CYCLE_OFFSET:   r_cfg.cycle_offset_ns <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/ctnc_datapath.sv
module ctnc_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ctnc_pkg::t_cfg  i_cfg,
    input  ctnc_pkg::t_cmd  i_cmd,
    input  logic            i_load,
    input  logic [63:0]     i_counter_value,
    output logic [63:0]     o_nanoseconds,
    output logic [63:0]     o_extended_count
);

    logic [63:0] r_last;
    logic [63:0] r_ext;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dvsr;
    logic [63:0] r_ns;
    logic [63:0] r_out_ext;

    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_mul_p;
    logic [63:0] w_ext_cat;
    logic [63:0] w_ext_v;
    logic [32:0] w_div_t;
    logic        w_div_ge;

    // one 32x32 multiplier, low half of the count first, then the high half
    always_comb begin
        w_mul_a = (i_cmd.op == ctnc_pkg::OP_MUL_HI) ? r_ext[63:32] : r_ext[31:0];
        case (i_cmd.mul_sel)
            ctnc_pkg::MUL_WHOLE: w_mul_b = {25'd0, i_cfg.period_whole_ns};
            ctnc_pkg::MUL_FRAC:  w_mul_b = {12'd0, i_cfg.period_frac_ppm};
            ctnc_pkg::MUL_PPM:   w_mul_b = ctnc_pkg::PPM_DIV;
            default:             w_mul_b = '0;
        endcase
        w_mul_p = 64'(w_mul_a) * 64'(w_mul_b);
    end

    // splice the 32-bit sample onto the tracked upper word, bump on wrap
    always_comb begin
        w_ext_cat = {r_last[63:32], r_ext[31:0]};
        w_ext_v   = (w_ext_cat < r_last) ? (w_ext_cat + ctnc_pkg::WRAP_STEP) : w_ext_cat;
    end

    // restoring division, one quotient bit a step
    always_comb begin
        w_div_t  = {r_rem, r_quo[63]};
        w_div_ge = (w_div_t >= {1'b0, r_dvsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_cmd.op == ctnc_pkg::OP_EXTEND && i_cfg.narrow_counter) begin
            if ((w_ext_v - r_last) > ctnc_pkg::HALF_WRAP) begin
                r_last <= w_ext_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ext <= i_counter_value;
        end
        case (i_cmd.op)
            ctnc_pkg::OP_EXTEND: begin
                if (i_cfg.narrow_counter) begin
                    r_ext <= w_ext_v;
                end
            end
            ctnc_pkg::OP_MUL_LO: begin
                // the finished whole-ns product moves aside as the next one starts
                r_acc  <= r_prod;
                r_prod <= w_mul_p;
            end
            ctnc_pkg::OP_MUL_HI: begin
                r_prod <= r_prod + {w_mul_p[31:0], 32'd0};
            end
            ctnc_pkg::OP_DIV_LOAD: begin
                r_quo  <= r_prod;
                r_rem  <= '0;
                r_dvsr <= (i_cfg.source_mode == ctnc_pkg::MODE_EVENT) ?
                          ctnc_pkg::PPM_DIV : i_cfg.cycle_rate_khz;
            end
            ctnc_pkg::OP_DIV_STEP: begin
                r_rem <= w_div_ge ? 32'(w_div_t - {1'b0, r_dvsr}) : w_div_t[31:0];
                r_quo <= {r_quo[62:0], w_div_ge};
            end
            ctnc_pkg::OP_FINISH: begin
                r_out_ext <= r_ext;
                unique case (i_cfg.source_mode)
                    ctnc_pkg::MODE_EVENT: r_ns <= r_acc + r_quo;
                    ctnc_pkg::MODE_CYCLE: r_ns <= r_quo + i_cfg.cycle_offset_ns;
                    default:              r_ns <= '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_nanoseconds    = r_ns;
    assign o_extended_count = r_out_ext;

endmodule

### hw/rtl/ctnc_ctrl.sv
module ctnc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_source_mode,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output ctnc_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXT,
        S_MW_LO,
        S_MW_HI,
        S_MF_LO,
        S_MF_HI,
        S_MC_LO,
        S_MC_HI,
        S_DLOAD,
        S_DIV,
        S_DONE
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [5:0] r_cnt;
    logic [5:0] n_cnt;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_in_take;
    logic       w_slot_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.op      = ctnc_pkg::OP_NONE;
        o_cmd.mul_sel = ctnc_pkg::MUL_PPM;
        unique case (r_state)
            S_IDLE:  o_cmd.op = ctnc_pkg::OP_NONE;
            S_EXT:   o_cmd.op = ctnc_pkg::OP_EXTEND;
            S_MW_LO: begin
                o_cmd.op      = ctnc_pkg::OP_MUL_LO;
                o_cmd.mul_sel = ctnc_pkg::MUL_WHOLE;
            end
            S_MW_HI: begin
                o_cmd.op      = ctnc_pkg::OP_MUL_HI;
                o_cmd.mul_sel = ctnc_pkg::MUL_WHOLE;
            end
            S_MF_LO: begin
                o_cmd.op      = ctnc_pkg::OP_MUL_LO;
                o_cmd.mul_sel = ctnc_pkg::MUL_FRAC;
            end
            S_MF_HI: begin
                o_cmd.op      = ctnc_pkg::OP_MUL_HI;
                o_cmd.mul_sel = ctnc_pkg::MUL_FRAC;
            end
            S_MC_LO: o_cmd.op = ctnc_pkg::OP_MUL_LO;
            S_MC_HI: o_cmd.op = ctnc_pkg::OP_MUL_HI;
            S_DLOAD: o_cmd.op = ctnc_pkg::OP_DIV_LOAD;
            S_DIV:   o_cmd.op = ctnc_pkg::OP_DIV_STEP;
            S_DONE:  o_cmd.op = w_slot_free ? ctnc_pkg::OP_FINISH : ctnc_pkg::OP_NONE;
            default: o_cmd.op = ctnc_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    unique case (i_source_mode)
                        ctnc_pkg::MODE_EVENT: n_state = S_EXT;
                        ctnc_pkg::MODE_CYCLE: n_state = S_MC_LO;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_EXT:   n_state = S_MW_LO;
            S_MW_LO: n_state = S_MW_HI;
            S_MW_HI: n_state = S_MF_LO;
            S_MF_LO: n_state = S_MF_HI;
            S_MF_HI: n_state = S_DLOAD;
            S_MC_LO: n_state = S_MC_HI;
            S_MC_HI: n_state = S_DLOAD;
            S_DLOAD: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (w_slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_take_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> o_in_stall)
        else $error("input taken but block not busy next cycle");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ctnc_pkg::OP_FINISH) |-> w_slot_free)
        else $error("result written over an unaccepted beat");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) && (r_state != S_DONE) && (r_state != S_IDLE) |-> (r_cnt == 6'd0)
        || (r_state != S_DLOAD))
        else $error("division counter not cleared before load");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ($past(r_state) == S_DIV) || ($past(r_state) == S_DLOAD))
        else $error("division entered without loading");

    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_cnt == 6'd63) |=> (r_state == S_DONE))
        else $error("division did not finish after 64 steps");

endmodule

### hw/rtl/counter_to_nanoseconds_converter.sv
// Counter sample to nanoseconds converter. Each input beat carries one raw
// counter sample and yields one output beat with the elapsed nanoseconds and
// the (possibly extended) tick count. The block works on one sample at a time.
// An event-timer sample passes through the extend step, the whole-ns and
// fractional-ns products, the divider load, the divider and the result
// register. A cycle-counter sample skips the extend step and forms one product
// instead. Most of the time goes to the 64-step restoring divider, which makes
// one quotient bit per cycle. Each 64x32 product takes a low and a high pass on
// the shared 32x32 multiplier. With no source selected, acceptance leads
// straight to the DONE state, which registers the result. The next sample is
// taken in the cycle after the previous result is registered. A stalled output
// holds the finished result back for as long as the stall lasts. The output
// register lets the next sample be accepted while a result waits.
// Write configuration only while no sample is in flight.
module counter_to_nanoseconds_converter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ctnc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ctnc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [63:0]                        i_counter_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [63:0]                        o_nanoseconds,
    output logic [63:0]                        o_extended_count
);

    ctnc_pkg::t_cfg w_cfg;
    ctnc_pkg::t_cmd w_cmd;
    logic           w_in_take;

    assign w_in_take = i_in_valid && !o_in_stall;

    ctnc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ctnc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_source_mode (w_cfg.source_mode),
        .i_in_valid    (i_in_valid),
        .i_out_stall   (i_out_stall),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_cmd         (w_cmd)
    );

    ctnc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .i_load           (w_in_take),
        .i_counter_value  (i_counter_value),
        .o_nanoseconds    (o_nanoseconds),
        .o_extended_count (o_extended_count)
    );

endmodule
